FILE: sv/bpc_pkg.sv
// Package for the barometric temperature / pressure compensation block.
// Payload, calibration and queue types plus shared helper functions.
// No dependencies.
`default_nettype none
package bpc_pkg;

  localparam int RawW   = 20;
  localparam int TempW  = 24;
  localparam int WordW  = 32;
  localparam int CalW   = 16;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  // Configuration register indexes
  localparam logic [2:0] REG_TEMP_CAL  = 3'd0;
  localparam logic [2:0] REG_PRESS_LO  = 3'd1;
  localparam logic [2:0] REG_PRESS_HI  = 3'd2;
  localparam logic [2:0] REG_PRESS_NIN = 3'd3;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature_centi;
    logic [WordW-1:0]        pressure_pa;
    logic                    pressure_invalid;
  } out_t;

  // Calibration words split out of the packed registers
  typedef struct packed {
    logic [CalW-1:0] t1, t2, t3;
    logic [CalW-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } cal_t;

  // One classified item waiting for the divide / correction back end
  typedef struct packed {
    logic [TempW-1:0] temp;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
    logic             post_dbl;
    logic             invalid;
  } job_t;

  // Arithmetic right shift of a 32-bit word
  function automatic logic [WordW-1:0] sra32(input logic [WordW-1:0] x, input logic [4:0] n);
    return $signed(x) >>> n;
  endfunction

  // Sign extend a 16-bit calibration word
  function automatic logic [WordW-1:0] sx16(input logic [CalW-1:0] w);
    return {{(WordW-CalW){w[CalW-1]}}, w};
  endfunction

endpackage
`default_nettype wire

FILE: sv/baro_temp_pressure_compensation.sv
// Barometric temperature / pressure compensation, 32-bit integer formulas.
// Input channel (in_valid / in_stall / in_data) takes one raw temperature
// and raw pressure pair per transfer; output channel (out_valid / out_stall
// / out_data) returns one result per pair: temperature in 0.01 degC,
// pressure in Pa and a flag for a zero pressure divisor (pressure then 0).
// Calibration is written over cfg_valid / cfg_ready / cfg_index / cfg_data
// while the block is idle; the user must keep to this, the block does not
// enforce it. cfg_ready is always high, unknown indexes are dropped. Throughput
// is one pair per cycle while in_stall is low. Items pass a 9-stage front
// pipeline of 32-bit multiplies, the queue, a 32-stage divider (one quotient
// bit per stage) and 4 correction stages. When out_valid and out_stall are
// high the back pipeline holds; the front keeps running into a 4-entry queue
// and raises in_stall once that queue is full. Synchronous reset empties all
// pipelines, clears calibration. Depends on bpc_pkg, bpc_front, bpc_queue, bpc_back.
`default_nettype none
module baro_temp_pressure_compensation (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bpc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bpc_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [63:0]   cfg_data
);
  import bpc_pkg::*;

  logic [47:0] temp_calibration;
  logic [63:0] press_calibration_low, press_calibration_high;
  logic [15:0] press_calibration_nine;
  cal_t        cal;
  logic        q_full, q_push, q_pop, q_valid;
  job_t        q_job, q_head;

  assign cfg_ready = 1'b1;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calibration       <= '0;
      press_calibration_low  <= '0;
      press_calibration_high <= '0;
      press_calibration_nine <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP_CAL:  temp_calibration       <= cfg_data[47:0];
        REG_PRESS_LO:  press_calibration_low  <= cfg_data;
        REG_PRESS_HI:  press_calibration_high <= cfg_data;
        REG_PRESS_NIN: press_calibration_nine <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = temp_calibration[15:0];
    cal.t2 = temp_calibration[31:16];
    cal.t3 = temp_calibration[47:32];
    cal.p1 = press_calibration_low[15:0];
    cal.p2 = press_calibration_low[31:16];
    cal.p3 = press_calibration_low[47:32];
    cal.p4 = press_calibration_low[63:48];
    cal.p5 = press_calibration_high[15:0];
    cal.p6 = press_calibration_high[31:16];
    cal.p7 = press_calibration_high[47:32];
    cal.p8 = press_calibration_high[63:48];
    cal.p9 = press_calibration_nine;
  end

  bpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cal      (cal),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  bpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  bpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .cal       (cal),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: sv/bpc_front.sv
// Front end: accepts raw sample pairs and runs the temperature and pressure
// formulas up to the divide, then classifies the divide. Uses bpc_pkg.
`default_nettype none
module bpc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bpc_pkg::in_t  in_data,
  input  wire bpc_pkg::cal_t cal,
  input  wire logic          q_full,
  output logic               q_push,
  output bpc_pkg::job_t      q_job
);
  import bpc_pkg::*;

  logic       en;
  logic [8:0] vld;

  logic [WordW-1:0] a, b, fine, tr, pv1;
  logic [WordW-1:0] f1_ma, f1_bb, f2_v1t, f2_mc, f3_v1, f3_q;
  logic [WordW-1:0] f4_qq, f4_m5, f4_m2, f5_s13, f5_m6, f5_m5, f5_m2;
  logic [WordW-1:0] f6_m3, f6_v2a, f6_m2, f7_v2, f7_v1c, f8_d, f8_u, f9_div, f9_num;
  logic [TempW-1:0] f3_temp, f4_temp, f5_temp, f6_temp, f7_temp, f8_temp, f9_temp;
  logic [RawW-1:0]  f1_rp, f2_rp, f3_rp, f4_rp, f5_rp, f6_rp, f7_rp;

  // Whole front pipeline holds while its last item cannot enter the queue
  assign en       = !(vld[8] && q_full);
  assign in_stall = !en;
  assign q_push   = vld[8] && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[7:0], in_valid};
    end
  end

  // Temperature terms
  assign a    = {15'b0, in_data.raw_temperature[19:3]} - {15'b0, cal.t1, 1'b0};
  assign b    = {16'b0, in_data.raw_temperature[19:4]} - {16'b0, cal.t1};
  assign fine = f2_v1t + sra32(f2_mc, 5'd14);
  assign tr   = sra32(fine * 32'd5 + 32'd128, 5'd8);
  assign pv1  = sra32(fine, 5'd1) - 32'd64000;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      f1_ma <= a * sx16(cal.t2);
      f1_bb <= b * b;
      f1_rp <= in_data.raw_pressure;
      // stage 2
      f2_v1t <= sra32(f1_ma, 5'd11);
      f2_mc  <= sra32(f1_bb, 5'd12) * sx16(cal.t3);
      f2_rp  <= f1_rp;
      // stage 3: fine temperature
      f3_temp <= tr[TempW-1:0];
      f3_v1   <= pv1;
      f3_q    <= sra32(pv1, 5'd2);
      f3_rp   <= f2_rp;
      // stage 4
      f4_qq   <= f3_q * f3_q;
      f4_m5   <= f3_v1 * sx16(cal.p5);
      f4_m2   <= sx16(cal.p2) * f3_v1;
      f4_temp <= f3_temp;
      f4_rp   <= f3_rp;
      // stage 5
      f5_s13  <= sra32(f4_qq, 5'd13);
      f5_m6   <= sra32(f4_qq, 5'd11) * sx16(cal.p6);
      f5_m5   <= f4_m5;
      f5_m2   <= f4_m2;
      f5_temp <= f4_temp;
      f5_rp   <= f4_rp;
      // stage 6
      f6_m3   <= sx16(cal.p3) * f5_s13;
      f6_v2a  <= f5_m6 + {f5_m5[30:0], 1'b0};
      f6_m2   <= f5_m2;
      f6_temp <= f5_temp;
      f6_rp   <= f5_rp;
      // stage 7
      f7_v2   <= sra32(f6_v2a, 5'd2) + {cal.p4, 16'b0};
      f7_v1c  <= 32'd32768 + sra32(sra32(f6_m3, 5'd3) + sra32(f6_m2, 5'd1), 5'd18);
      f7_temp <= f6_temp;
      f7_rp   <= f6_rp;
      // stage 8
      f8_d    <= f7_v1c * {16'b0, cal.p1};
      f8_u    <= (32'd1048576 - {12'b0, f7_rp}) - sra32(f7_v2, 5'd12);
      f8_temp <= f7_temp;
      // stage 9
      f9_div  <= sra32(f8_d, 5'd15);
      f9_num  <= f8_u * 32'd3125;
      f9_temp <= f8_temp;
    end
  end

  // Classify: zero divisor, and whether the numerator can be doubled first
  always_comb begin
    q_job.temp     = f9_temp;
    q_job.divisor  = f9_div;
    q_job.invalid  = (f9_div == '0);
    q_job.post_dbl = f9_num[31];
    q_job.dividend = f9_num[31] ? f9_num : {f9_num[30:0], 1'b0};
  end

endmodule
`default_nettype wire

FILE: sv/bpc_queue.sv
// Short queue of classified items between front and back end.
// Uses bpc_pkg for the item type and depth.
`default_nettype none
module bpc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bpc_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output bpc_pkg::job_t      head_data
);
  import bpc_pkg::*;

  job_t             slots [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW:0]   count;
  logic             do_pop;

  assign full       = (count == (QPtrW+1)'(QDepth));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPtrW+1)'(push) - (QPtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

FILE: sv/bpc_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage,
// then the second-order pressure correction. Uses bpc_pkg.
`default_nettype none
module bpc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire bpc_pkg::job_t q_data,
  output logic               q_pop,
  input  wire bpc_pkg::cal_t cal,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bpc_pkg::out_t      out_data
);
  import bpc_pkg::*;

  logic             en;
  logic [WordW-1:0] dv_rem  [WordW];
  logic [WordW-1:0] dv_dvd  [WordW];
  logic [WordW-1:0] dv_div  [WordW];
  logic [TempW-1:0] dv_temp [WordW];
  logic [WordW-1:0] dv_post, dv_inv, dv_vld;

  logic [2:0]       cv_vld;
  logic [WordW-1:0] b1_p, b2_p, b2_pp, b2_m8, b3_p, b3_w1m, b3_w2, corr;
  logic [TempW-1:0] b1_temp, b2_temp, b3_temp;
  logic [2:0]       cv_inv;

  // Back pipeline moves whenever the output register can be refilled
  assign en    = !out_valid || !out_stall;
  assign q_pop = en;

  // Divider stages
  for (genvar k = 0; k < WordW; k++) begin : g_div
    logic [WordW-1:0] rem_in, dvd_in, div_in;
    logic [TempW-1:0] temp_in;
    logic             post_in, inv_in;
    logic [WordW:0]   trial;
    logic             fits;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign dvd_in  = q_data.dividend;
      assign div_in  = q_data.divisor;
      assign temp_in = q_data.temp;
      assign post_in = q_data.post_dbl;
      assign inv_in  = q_data.invalid;
    end else begin : g_rest
      assign rem_in  = dv_rem[k-1];
      assign dvd_in  = dv_dvd[k-1];
      assign div_in  = dv_div[k-1];
      assign temp_in = dv_temp[k-1];
      assign post_in = dv_post[k-1];
      assign inv_in  = dv_inv[k-1];
    end
    assign trial = {rem_in, dvd_in[WordW-1]};
    assign fits  = (trial >= {1'b0, div_in});

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k]  <= fits ? 32'(trial - {1'b0, div_in}) : trial[WordW-1:0];
        dv_dvd[k]  <= {dvd_in[WordW-2:0], fits};
        dv_div[k]  <= div_in;
        dv_temp[k] <= temp_in;
        dv_post[k] <= post_in;
        dv_inv[k]  <= inv_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld    <= '0;
      cv_vld    <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      dv_vld    <= {dv_vld[WordW-2:0], q_valid};
      cv_vld    <= {cv_vld[1:0], dv_vld[WordW-1]};
      out_valid <= cv_vld[2];
    end
  end

  // Final correction sum
  assign corr = sra32(sra32(b3_w1m, 5'd12) + b3_w2 + sx16(cal.p7), 5'd4);

  always_ff @(posedge clk) begin
    if (en) begin
      b1_p      <= dv_post[WordW-1] ? {dv_dvd[WordW-1][30:0], 1'b0} : dv_dvd[WordW-1];
      b1_temp   <= dv_temp[WordW-1];
      cv_inv[0] <= dv_inv[WordW-1];
      b2_pp     <= {3'b0, b1_p[31:3]} * {3'b0, b1_p[31:3]};
      b2_m8     <= {2'b0, b1_p[31:2]} * sx16(cal.p8);
      b2_p      <= b1_p;
      b2_temp   <= b1_temp;
      cv_inv[1] <= cv_inv[0];
      b3_w1m    <= sx16(cal.p9) * {13'b0, b2_pp[31:13]};
      b3_w2     <= sra32(b2_m8, 5'd13);
      b3_p      <= b2_p;
      b3_temp   <= b2_temp;
      cv_inv[2] <= cv_inv[1];
      out_data.temperature_centi <= b3_temp;
      out_data.pressure_pa       <= cv_inv[2] ? '0 : b3_p + corr;
      out_data.pressure_invalid  <= cv_inv[2];
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for baro_temp_pressure_compensation.
// Predicts each compensated temperature / pressure result and checks it in order.
// Depends on bpc_pkg and the block's RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd5;   // index with no register behind it
  localparam int         WdogLimit  = 5000;
  localparam int         DrainWait  = 60;

  // Expected-result store plus the 32-bit compensation math
  class comp_checker;
    logic [47:0] temp_cal;
    logic [63:0] press_lo, press_hi;
    logic [15:0] press_nine;
    out_t        pending_results[$];
    int          errors;

    function new();
      temp_cal = '0; press_lo = '0; press_hi = '0; press_nine = '0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_TEMP_CAL:  temp_cal = val[47:0];
        REG_PRESS_LO:  press_lo = val;
        REG_PRESS_HI:  press_hi = val;
        REG_PRESS_NIN: press_nine = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] asr(logic [31:0] x, int n);
      return $signed(x) >>> n;
    endfunction

    function logic [31:0] sext(logic [15:0] w);
      return {{16{w[15]}}, w};
    endfunction

    function out_t compensate(in_t d);
      logic [31:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] a, b, v1, v2, q, fine, temp, p, w1, w2, prod, sq;
      out_t r;
      rt = {12'b0, d.raw_temperature};
      rp = {12'b0, d.raw_pressure};
      t1 = {16'b0, temp_cal[15:0]};
      t2 = sext(temp_cal[31:16]);
      t3 = sext(temp_cal[47:32]);
      p1 = {16'b0, press_lo[15:0]};
      p2 = sext(press_lo[31:16]);
      p3 = sext(press_lo[47:32]);
      p4 = sext(press_lo[63:48]);
      p5 = sext(press_hi[15:0]);
      p6 = sext(press_hi[31:16]);
      p7 = sext(press_hi[47:32]);
      p8 = sext(press_hi[63:48]);
      p9 = sext(press_nine);
      // temperature and fine term
      a = (rt >> 3) - (t1 << 1);
      prod = a * t2;
      v1 = asr(prod, 11);
      b = (rt >> 4) - t1;
      prod = b * b;
      prod = asr(prod, 12) * t3;
      v2 = asr(prod, 14);
      fine = v1 + v2;
      prod = fine * 32'd5 + 32'd128;
      temp = asr(prod, 8);
      // pressure divisor and offset terms
      v1 = asr(fine, 1) - 32'd64000;
      q = asr(v1, 2);
      sq = q * q;
      v2 = asr(sq, 11) * p6;
      prod = v1 * p5;
      v2 = v2 + (prod << 1);
      v2 = asr(v2, 2) + (p4 << 16);
      prod = p3 * asr(sq, 13);
      a = asr(prod, 3);
      prod = p2 * v1;
      b = asr(prod, 1);
      v1 = asr(a + b, 18);
      prod = (32'd32768 + v1) * p1;
      v1 = asr(prod, 15);
      r.temperature_centi = temp[23:0];
      if (v1 == 0) begin
        r.pressure_pa = '0;
        r.pressure_invalid = 1'b1;
      end else begin
        p = ((32'd1048576 - rp) - asr(v2, 12)) * 32'd3125;
        if (p < 32'h8000_0000) begin
          prod = p << 1;
          p = prod / v1;
        end else begin
          prod = p / v1;
          p = prod * 32'd2;
        end
        sq = (p >> 3) * (p >> 3);
        prod = p9 * (sq >> 13);
        w1 = asr(prod, 12);
        prod = (p >> 2) * p8;
        w2 = asr(prod, 13);
        p = p + asr(w1 + w2 + p7, 4);
        r.pressure_pa = p;
        r.pressure_invalid = 1'b0;
      end
      return r;
    endfunction

    function void note_input(in_t d);
      pending_results.push_back(compensate(d));
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_t got);
      out_t exp_r;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.temperature_centi !== exp_r.temperature_centi)
        report_mismatch($sformatf("temperature_centi got %0h exp %0h",
                                  got.temperature_centi, exp_r.temperature_centi));
      if (got.pressure_pa !== exp_r.pressure_pa)
        report_mismatch($sformatf("pressure_pa got %0h exp %0h",
                                  got.pressure_pa, exp_r.pressure_pa));
      if (got.pressure_invalid !== exp_r.pressure_invalid)
        report_mismatch($sformatf("pressure_invalid got %0b exp %0b",
                                  got.pressure_invalid, exp_r.pressure_invalid));
    endtask
  endclass

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_t         in_data;
  out_t        out_data;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int          send_idle_pct, recv_stall_pct, quiet_cycles;
  comp_checker sb = new();

  baro_temp_pressure_compensation i_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Transfer monitor: feeds the predictor and checks results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
        (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver stall
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_pair(in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_raw(logic [19:0] t, logic [19:0] p);
    in_t d;
    d.raw_temperature = t;
    d.raw_pressure = p;
    send_pair(d);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Let all expected results come back, then let the pipe settle
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_results.size() > 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic load_cal(logic [47:0] tc, logic [63:0] lo, logic [63:0] hi,
                          logic [15:0] nine);
    cfg_write(REG_TEMP_CAL, {16'hFFFF, tc});   // upper bits must be dropped
    cfg_write(REG_PRESS_LO, lo);
    cfg_write(REG_PRESS_HI, hi);
    cfg_write(REG_PRESS_NIN, {48'hFFFF_FFFF_FFFF, nine});
  endtask

  task automatic set_pace(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default: begin send_idle_pct = 6; recv_stall_pct = 6; end
    endcase
  endtask

  initial begin
    logic [47:0] tc;
    logic [63:0] lo, hi;
    logic [15:0] nine;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Reset calibration: divisor is zero, pressure flagged invalid
    send_raw(20'h0, 20'h0);
    send_raw(20'hFFFFF, 20'hFFFFF);
    send_raw(20'h7EEE0, 20'h655AC);
    drain();

    // Typical datasheet calibration
    load_cal({16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'd3024, 16'hD843, 16'd36477},
             {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
    send_raw(20'd519888, 20'd415148);
    send_raw(20'h0, 20'h0);
    send_raw(20'hFFFFF, 20'hFFFFF);
    send_raw(20'h0, 20'hFFFFF);
    send_raw(20'hFFFFF, 20'h0);
    send_raw(20'h80000, 20'h80000);
    drain();
    // Unknown index is ignored
    cfg_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_raw(20'd519888, 20'd415148);
    drain();

    // Extreme words: all ones, then most negative / most positive signed
    load_cal('1, '1, '1, '1);
    send_raw(20'h0, 20'h0);
    send_raw(20'hFFFFF, 20'hFFFFF);
    send_raw(20'h12345, 20'hABCDE);
    drain();
    load_cal({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
             {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
    send_raw(20'h0, 20'hFFFFF);
    send_raw(20'hFFFFF, 20'h0);
    send_raw(20'h55555, 20'hAAAAA);
    drain();

    // Random phases over several calibrations and pacing modes
    for (int ph = 0; ph < 8; ph++) begin
      set_pace(ph % 4);
      if (ph == 0) begin
        load_cal({16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD843, 16'd36477},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
      end else begin
        tc = 48'({$urandom, $urandom});
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        nine = 16'($urandom);
        if (ph == 5) lo[15:0] = '0;   // zero divisor phase
        load_cal(tc, lo, hi, nine);
      end
      for (int k = 0; k < 160; k++) begin
        if (ph == 0 && $urandom_range(3) != 0)
          send_raw(20'(20'd519888 + $urandom_range(65535) - 32768),
                   20'(20'd415148 + $urandom_range(131071) - 65536));
        else
          send_raw(20'($urandom), 20'($urandom));
      end
      // a stretch with no idling inside every phase
      set_pace(0);
      for (int k = 0; k < 12; k++) send_raw(20'($urandom), 20'($urandom));
      drain();
    end

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
